>>> hw/rtl/div_pkg.sv
// Shared types and constants for the serial 32-bit divider.
// No dependencies; compile first.

package div_pkg;

    // Default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // Operation select carried with each request
    typedef enum logic [1:0] {
        ACT_UQUO = 2'd0,
        ACT_UREM = 2'd1,
        ACT_SQUO = 2'd2,
        ACT_SREM = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } state_t;

endpackage

>>> hw/rtl/div_if.sv
// Request and result channel interfaces for the serial divider.
// Depends on div_pkg.

interface div_req_if #(
    parameter int DATA_WIDTH = div_pkg::DATA_WIDTH_DEF
);
    import div_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output action, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input action, input dividend, input divisor,
                    output ready);
endinterface

interface div_res_if #(
    parameter int DATA_WIDTH = div_pkg::DATA_WIDTH_DEF
);
    import div_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

>>> hw/rtl/divide_32bit_signed_unsigned.sv
// Top level of the serial restoring divider (quotient or remainder,
// signed or unsigned). Depends on div_pkg and div_if.
//
//   channel | dir | payload                       | note
//   --------+-----+-------------------------------+---------------------------
//   req     | in  | action, dividend, divisor     | taken only while idle
//   res     | out | result                        | held in an output register
//
// An item is accepted in an idle cycle, which loads the operand magnitudes;
// then the shared subtract-and-shift step runs in ST_DIV, one quotient bit
// per step for all DATA_WIDTH quotient bits; then ST_FIX does the sign
// fix-up and writes the output register. The next request is taken in the
// idle cycle right after the fix-up has written the output register, even
// if that result has not yet been taken.
// A stalled result holds the sequencer in fix-up until the register frees.
// Reset (rst_n low) clears the sequencer and the result valid flag.

module divide_32bit_signed_unsigned #(
    parameter int DATA_WIDTH = div_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    div_req_if.sink    req,
    div_res_if.source  res
);
    import div_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    action_t               action_reg, action_next;
    logic                  a_neg_reg, a_neg_next;
    logic                  q_neg_reg, q_neg_next;
    logic [DATA_WIDTH-1:0] num_reg, num_next;
    logic [DATA_WIDTH-1:0] den_reg, den_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic                  res_valid_reg, res_valid_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    logic                  accept;
    logic                  step;
    logic                  fix_done;
    logic                  is_signed;
    logic                  a_neg, b_neg;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH+1:0] diff;
    logic                  take;
    logic [DATA_WIDTH-1:0] fix_val;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (!res_valid_reg || res.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        step      = 1'b0;
        fix_done  = 1'b0;
        case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_DIV:  step      = 1'b1;
            ST_FIX:  fix_done  = !res_valid_reg || res.ready;
            default: req.ready = 1'b0;
        endcase
    end

    assign accept = req.valid && req.ready;

    // Operand signs and the subtract-and-shift step
    assign is_signed = req.action[1];
    assign a_neg     = is_signed && req.dividend[DATA_WIDTH-1];
    assign b_neg     = is_signed && req.divisor[DATA_WIDTH-1];
    assign rem_sh    = {rem_reg, num_reg[DATA_WIDTH-1]};
    assign diff      = {1'b0, rem_sh} - {2'b00, den_reg};
    assign take      = !diff[DATA_WIDTH+1];

    // Sign fix-up of the finished quotient or remainder
    always_comb
    begin
        case (action_reg)
            ACT_UQUO: fix_val = num_reg;
            ACT_UREM: fix_val = rem_reg;
            ACT_SQUO: fix_val = q_neg_reg ? (~num_reg + 1'b1) : num_reg;
            default:  fix_val = a_neg_reg ? (~rem_reg + 1'b1) : rem_reg;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        action_next    = action_reg;
        a_neg_next     = a_neg_reg;
        q_neg_next     = q_neg_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        res_valid_next = res_valid_reg;
        result_next    = result_reg;

        // load magnitudes on a new request
        if (accept)
        begin
            cnt_next    = CNT_W'(DATA_WIDTH - 1);
            action_next = action_t'(req.action);
            a_neg_next  = a_neg;
            q_neg_next  = a_neg ^ b_neg;
            num_next    = a_neg ? (~req.dividend + 1'b1) : req.dividend;
            den_next    = b_neg ? (~req.divisor + 1'b1) : req.divisor;
            rem_next    = '0;
        end

        // shift in one quotient bit, restore when the subtract borrows
        if (step)
        begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[DATA_WIDTH-2:0], take};
            rem_next = take ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        end

        // drop the taken result, then load a new one
        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;
        if (fix_done)
        begin
            res_valid_next = 1'b1;
            result_next    = fix_val;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        a_neg_reg  <= a_neg_next;
        q_neg_reg  <= q_neg_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    assign res.valid  = res_valid_reg;
    assign res.result = result_reg;

endmodule

>>> hw/rtl/div_checker.sv
// Port-level checks for the serial divider, bound to its top level.
// Depends on div_pkg and divide_32bit_signed_unsigned.

module div_checker #(
    parameter int DATA_WIDTH = div_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [DATA_WIDTH-1:0] res_result
);
    import div_pkg::*;

    // A stalled result stays and holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_result))
    else $error("stalled result changed");

    // One request at a time: the block is busy right after taking one
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

    // A new result is written only from fix-up, never while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(req_ready))
    else $error("result appeared without a division in flight");

    // No request is taken in the same cycle as a new result is written
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!(req_valid && req_ready)))
    else $error("request taken during fix-up");

endmodule

bind divide_32bit_signed_unsigned div_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_div_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_result (res.result)
);
